[rtl/core/grbf_pkg.sv]
// grbf_pkg: shared types and constants for the gaussian rbf kernel evaluator
// no dependencies
package grbf_pkg;

	localparam int unsigned COORD_W  = 16;
	localparam int unsigned ACC_W    = 41;
	localparam int unsigned DIST_W   = 32;
	localparam int unsigned KERN_W   = 16;
	localparam int unsigned W2_W     = 32;
	localparam int unsigned Q_W      = 32;
	localparam int unsigned QF_W     = 33;
	localparam logic [DIST_W-1:0] CUTOFF_RESET = 32'd6553600;
	localparam logic [DIST_W-1:0] EXP_LIMIT    = 32'd786432;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] center_coord;
		logic [COORD_W-1:0]        center_width;
		logic                      last_coord;
	} in_item_t;

	typedef struct packed {
		logic [KERN_W-1:0] kernel_value;
		logic [DIST_W-1:0] scaled_distance;
		logic              cutoff_hit;
		logic              zero_width;
	} out_item_t;

	// one finished vector handed from front to back
	typedef struct packed {
		logic [ACC_W-1:0]   acc;
		logic [COORD_W-1:0] width;
	} vec_job_t;

endpackage

[rtl/core/grbf_front.sv]
// grbf_front: accumulates squared coordinate differences, emits one job per vector
// depends on grbf_pkg
module grbf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  grbf_pkg::in_item_t  in_item,
	output logic                job_valid,
	input  logic                job_ready,
	output grbf_pkg::vec_job_t  job
);
	import grbf_pkg::*;

	logic [ACC_W-1:0]            acc_q;
	logic signed [COORD_W:0]     diff;
	logic [2*COORD_W+1:0]        sq;
	logic [ACC_W:0]              sum;
	logic [ACC_W-1:0]            sat;
	logic                        take;

	assign in_stall = in_item.last_coord & ~job_ready;
	assign take     = in_valid & ~in_stall;

	always_comb begin
		diff = {in_item.x_coord[COORD_W-1], in_item.x_coord}
			- {in_item.center_coord[COORD_W-1], in_item.center_coord};
		sq   = (2*COORD_W+2)'(diff * diff);
		sum  = {1'b0, acc_q} + (ACC_W+1)'(sq[2*COORD_W:0]);
		sat  = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
	end

	assign job_valid = in_valid & in_item.last_coord;
	assign job.acc   = sat;
	assign job.width = in_item.center_width;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (take) begin
			acc_q <= in_item.last_coord ? '0 : sat;
		end
	end
endmodule

[rtl/core/grbf_queue.sv]
// grbf_queue: small fifo of vector jobs between front and back
// depends on grbf_pkg
module grbf_queue #(
	parameter int unsigned DEPTH = grbf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_valid,
	output logic               wr_ready,
	input  grbf_pkg::vec_job_t wr_data,
	output logic               rd_valid,
	input  logic               rd_ready,
	output grbf_pkg::vec_job_t rd_data
);
	import grbf_pkg::*;
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	vec_job_t        mem_q [DEPTH];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;
	logic            wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid & wr_ready;
	assign rd = rd_valid & rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
endmodule

[rtl/core/grbf_back.sv]
// grbf_back: restoring divide, polynomial exp and eight squarings per vector
// depends on grbf_pkg
module grbf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  grbf_pkg::vec_job_t job,
	input  logic [31:0]        cutoff,
	output logic               res_valid,
	input  logic               res_stall,
	output grbf_pkg::out_item_t res
);
	import grbf_pkg::*;

	// ceil(2^33 / 3): exact floor(x / 3) for any 32 bit x after >> 33
	localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;

	typedef enum logic [3:0] {
		S_IDLE, S_SQ, S_DIV, S_CHK, S_P2, S_P3, S_P4, S_P5, S_D6, S_D24, S_SUM, S_POW,
		S_KRN, S_OUT
	} state_t;

	state_t             state_q;
	logic [W2_W-1:0]    w2_q;
	logic [56:0]        num_q;   // acc << 16, shifted out msb first
	logic [QF_W-1:0]    rem_q;
	logic [QF_W-1:0]    quo_q;   // 33 bits; bit 32 means saturation
	logic [5:0]         cnt_q;
	logic [DIST_W-1:0]  dist_q;
	logic [31:0]        y_q, p2_q, p3_q, p4_q;
	logic [31:0]        d6_q, d24_q;
	logic [32:0]        e_q;
	logic [15:0]        w_q;
	out_item_t          wrk_q;
	out_item_t          res_q;
	logic               res_v_q;

	logic [QF_W:0]      trial;
	logic [63:0]        mul;
	logic [31:0]        mul_a, mul_b;
	logic [33:0]        esum;
	logic [48:0]        kr;

	assign trial = {rem_q, num_q[56]} - {2'b0, w2_q};

	always_comb begin
		mul_a = y_q; mul_b = y_q;
		case (state_q)
			S_P4:    mul_a = p2_q;
			S_P5:    mul_a = p3_q;
			S_D6:    begin mul_a = p3_q; mul_b = RECIP3; end
			S_D24:   begin mul_a = p4_q; mul_b = RECIP3; end
			S_POW:   begin mul_a = e_q[31:0]; mul_b = e_q[31:0]; end
			default: mul_a = y_q;
		endcase
		mul  = mul_a * mul_b;
		esum = 34'h80000000 - 34'(y_q) + 34'(p2_q >> 1) - 34'(d6_q) + 34'(d24_q);
		kr   = ({e_q[31:0], 16'h0} + 49'h40000000) >> 31;
	end

	assign job_ready = state_q == S_IDLE;
	assign res_valid = res_v_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_v_q <= 1'b0;
		end else begin
			if (res_v_q && !res_stall && state_q != S_OUT) res_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (job_valid) begin
					w_q   <= job.width;
					num_q <= {job.acc, 16'h0};
					state_q <= S_SQ;
				end
				S_SQ: begin
					w2_q  <= 32'(w_q * w_q);
					rem_q <= '0; quo_q <= '0; cnt_q <= '0;
					state_q <= (w_q == '0) ? S_OUT : S_DIV;
					wrk_q <= '{kernel_value: '0, scaled_distance: '1,
						cutoff_hit: 1'b0, zero_width: 1'b1};
				end
				S_DIV: begin
					if (!trial[QF_W]) rem_q <= trial[QF_W-1:0];
					else rem_q <= {rem_q[QF_W-2:0], num_q[56]};
					// a quotient bit above bit 32 only matters as saturation
					if (quo_q == {QF_W{1'b1}} || (!trial[QF_W] && cnt_q < 6'd24))
						quo_q <= {QF_W{1'b1}};
					else
						quo_q <= {quo_q[QF_W-2:0], ~trial[QF_W]};
					num_q <= {num_q[55:0], 1'b0};
					if (cnt_q == 6'd56) state_q <= S_CHK;
					cnt_q <= cnt_q + 1'b1;
				end
				S_CHK: begin
					dist_q <= quo_q[32] ? '1 : quo_q[31:0];
					state_q <= S_P2;
				end
				S_P2: begin
					y_q <= {dist_q[24:0], 7'b0};
					wrk_q.scaled_distance <= dist_q;
					wrk_q.zero_width <= 1'b0;
					wrk_q.cutoff_hit <= dist_q > cutoff;
					wrk_q.kernel_value <= '0;
					if (dist_q > cutoff || dist_q >= EXP_LIMIT) state_q <= S_OUT;
					else state_q <= S_P3;
				end
				S_P3: begin p2_q <= 32'(mul >> 31); state_q <= S_P4; end
				S_P4: begin p3_q <= 32'(mul >> 31); state_q <= S_P5; end
				S_P5: begin p4_q <= 32'(mul >> 31); state_q <= S_D6; end
				S_D6: begin d6_q <= 32'(mul >> 34); state_q <= S_D24; end
				S_D24: begin d24_q <= 32'(mul >> 36); state_q <= S_SUM; end
				S_SUM: begin
					e_q <= 33'(esum);
					cnt_q <= '0;
					state_q <= S_POW;
				end
				S_POW: begin
					e_q <= 33'(mul >> 31);
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd7) state_q <= S_KRN;
				end
				S_KRN: begin
					wrk_q.kernel_value <= (kr > 49'd65535) ? 16'hFFFF : kr[15:0];
					state_q <= S_OUT;
				end
				S_OUT: if (!res_v_q || !res_stall) begin
					res_v_q <= 1'b1;
					res_q   <= wrk_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/core/gaussian_rbf_kernel_eval.sv]
// gaussian_rbf_kernel_eval: top level, front accumulator, job queue, back evaluator
// depends on grbf_pkg, grbf_front, grbf_queue, grbf_back
//
// usage
//  in channel: one coordinate pair per transfer (valid/stall); the front
//  accumulates one pair per cycle into a 41 bit saturating sum
//  the pair marked last_coord closes the vector and pushes a job into a
//  small queue; it stalls only when that queue is full
//  out channel: one result per vector (valid/stall), held in an output
//  register while the receiver stalls; the back end keeps its next result
//  until that register is free
//  cfg channel: valid/ready write of the cutoff register, always ready
//  after the last pair the job passes through the queue to the back end; a
//  zero width goes straight to the output register, every other vector runs
//  the bit-serial divider (57 steps), then the series terms and the eight exp
//  squarings unless it is past cutoff or at distance >= 12.0
//  throughput: one pair per cycle within a vector; the back end takes a new
//  vector only once its previous result is in the output register
//  reset: accumulator cleared, queue empty, cutoff = 100.0 (Q16.16)
module gaussian_rbf_kernel_eval #(
	parameter int unsigned QUEUE_DEPTH = grbf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  grbf_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output grbf_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [31:0]          cfg_data
);
	import grbf_pkg::*;

	logic [DIST_W-1:0] cutoff_q;
	logic      fj_valid, fj_ready, bj_valid, bj_ready;
	vec_job_t  fj, bj;

	assign cfg_ready = 1'b1;

	// cutoff register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= CUTOFF_RESET;
		end else if (cfg_valid) begin
			cutoff_q <= cfg_data;
		end
	end

	grbf_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_item(in_data),
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
	);

	grbf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
		.rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
	);

	grbf_back u_back (
		.clk, .arst_n, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
		.cutoff(cutoff_q), .res_valid(out_valid), .res_stall(out_stall),
		.res(out_data)
	);
endmodule
